### rtl/core/snapshot_frame_checker_core_assert.svh
// Assertion macros shared by the snapshot frame checker RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef SNAPSHOT_FRAME_CHECKER_CORE_ASSERT_SVH
`define SNAPSHOT_FRAME_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFC_ASSERT_NOW(lbl, ante, cons, msg)
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/sfc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the snapshot frame checker.
// No dependencies.
package sfc_pkg;

	localparam int HEADER_BYTES = 36;
	localparam int CRC_POS      = 32;
	localparam int COUNT_WIDTH  = 27;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [15:0] EXP_VERSION_RST = 16'd1;
	localparam logic [26:0] MAX_PAYLOAD_RST = 27'd67108864;

	localparam logic [7:0] MAGIC_0 = 8'h4D; // 'M'
	localparam logic [7:0] MAGIC_1 = 8'h53; // 'S'
	localparam logic [7:0] MAGIC_2 = 8'h4E; // 'N'
	localparam logic [7:0] MAGIC_3 = 8'h50; // 'P'

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_TRUNC     = 4'd1,
		ST_MAGIC     = 4'd2,
		ST_VERSION   = 4'd3,
		ST_HDR_SIZE  = 4'd4,
		ST_TYPE_ZERO = 4'd5,
		ST_TOO_LARGE = 4'd6,
		ST_SIZE_MISM = 4'd7,
		ST_CRC       = 4'd8
	} status_t;

	// register word index (paddr[2])
	typedef enum logic {
		REG_EXP_VERSION = 1'b0,
		REG_MAX_PAYLOAD = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] expected_version;
		logic [26:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	// reflected CRC-32, one byte, unrolled over 8 bit steps
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

### rtl/core/sfc_frame_if.sv
// Byte channel carrying one frame byte per transfer.
// No dependencies.
interface sfc_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/sfc_result_if.sv
// Result channel: check status plus captured header fields, one per frame.
// No dependencies.
interface sfc_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [15:0] hdr_version;
	logic [15:0] hdr_payload_type;
	logic [15:0] hdr_flags;
	logic [63:0] hdr_frame_number;
	logic [63:0] hdr_rng_state;
	logic [31:0] hdr_payload_size;

	modport source (output valid, output status, output hdr_version,
		output hdr_payload_type, output hdr_flags, output hdr_frame_number,
		output hdr_rng_state, output hdr_payload_size, input ready);
	modport sink (input valid, input status, input hdr_version,
		input hdr_payload_type, input hdr_flags, input hdr_frame_number,
		input hdr_rng_state, input hdr_payload_size, output ready);
endinterface

### rtl/core/snapshot_frame_checker_core.sv
// Snapshot frame checker, top level: byte channel in, result channel out, APB registers.
// Depends on sfc_pkg, sfc_frame_if, sfc_result_if, sfc_cfg_regs, sfc_in_stage, sfc_frame.
//
// Usage:
//  - frame: one byte per transfer, last_byte marks the final byte of a frame.
//    The first 36 bytes form the little-endian header (magic, version, header
//    size, type, flags, frame number, RNG state, payload size, CRC).
//  - result: one transfer per frame, issued for the last byte only, carrying
//    the first failing check (or OK) and the captured header fields.
//  - APB: word 0 expected version, word 1 max payload size. Write only
//    while no frame is in flight.
// Throughput: one byte per cycle while no last byte is held by a stall; the CRC-32
//  step is unrolled over the full byte in the frame stage, so no byte waits on another.
// Path: an accepted byte is held in the input register; a last byte then loads
//  the result register, which drives result.valid.
// Reset: arst_n clears the counter, CRC and captured header, drops both valids
//  and restores register defaults (version 1, max payload 64 MiB).
// Stall: a pending result holds while result.ready is low; non-last bytes
//  keep flowing, and only a second last byte waits in the input register.
module snapshot_frame_checker_core (
	input  logic         clk,
	input  logic         arst_n,
	sfc_frame_if.sink    frame,
	sfc_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	sfc_pkg::cfg_t  cfg;
	sfc_pkg::beat_t beat_s1;
	logic           valid_s1;
	logic           advance;

	// configuration registers
	sfc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register; refills in the same cycle it drains
	sfc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	// counter, capture, CRC and checks feeding the result register
	sfc_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.advance  (advance),
		.result   (result)
	);

endmodule

### rtl/core/sfc_cfg_regs.sv
// APB-style register file: expected version and payload size limit.
// Depends on sfc_pkg.
module sfc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output sfc_pkg::cfg_t       cfg
);

	sfc_pkg::cfg_t    cfg_q;
	sfc_pkg::reg_idx_t sel;
	logic             wr_en;

	assign sel    = sfc_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= sfc_pkg::EXP_VERSION_RST;
			cfg_q.max_payload      <= sfc_pkg::MAX_PAYLOAD_RST;
		end else if (wr_en) begin
			case (sel)
				sfc_pkg::REG_EXP_VERSION: cfg_q.expected_version <= pwdata[15:0];
				sfc_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload      <= pwdata[26:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			sfc_pkg::REG_EXP_VERSION: prdata = {16'd0, cfg_q.expected_version};
			sfc_pkg::REG_MAX_PAYLOAD: prdata = {5'd0, cfg_q.max_payload};
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/sfc_in_stage.sv
// Input register stage: holds one accepted byte until the frame stage takes it.
// Depends on sfc_pkg and sfc_frame_if.
module sfc_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	sfc_frame_if.sink      frame,
	input  logic           advance,
	output logic           valid_s1,
	output sfc_pkg::beat_t beat_s1
);

	logic take;

	// a byte enters when the slot is empty or its holder moves on this cycle
	assign frame.ready = !valid_s1 || advance;
	assign take        = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1.data_byte <= frame.data_byte;
			beat_s1.last_byte <= frame.last_byte;
		end
	end

endmodule

### rtl/core/sfc_frame.sv
// Frame stage: byte counter, header capture, CRC-32 update, status and result register.
// Depends on sfc_pkg, sfc_result_if and the assertion macro header.
`include "snapshot_frame_checker_core_assert.svh"

module sfc_frame (
	input  logic           clk,
	input  logic           arst_n,
	input  sfc_pkg::cfg_t  cfg,
	input  logic           valid_s1,
	input  sfc_pkg::beat_t beat_s1,
	output logic           advance,
	sfc_result_if.source   result
);

	localparam int CW = sfc_pkg::COUNT_WIDTH;
	localparam int HB = sfc_pkg::HEADER_BYTES;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] len;
	logic [31:0]   crc_q;
	logic [31:0]   crc_nxt;
	logic [7:0]    crc_in;
	logic [7:0]    hdr_q   [HB];
	logic [7:0]    hdr_nxt [HB];
	logic          fire;
	logic          stall;

	logic [15:0] f_version, f_hdr_size, f_type, f_flags;
	logic [63:0] f_frame, f_rng;
	logic [31:0] f_size, f_crc;
	logic        magic_ok;
	sfc_pkg::status_t status;

	logic        res_valid_q;
	logic [3:0]  res_status_q;
	logic [15:0] res_version_q, res_type_q, res_flags_q;
	logic [63:0] res_frame_q, res_rng_q;
	logic [31:0] res_size_q;

	// only a last byte needs the result register
	assign stall   = valid_s1 && beat_s1.last_byte && res_valid_q && !result.ready;
	assign advance = !stall;
	assign fire    = valid_s1 && !stall;

	always_comb begin
		for (int i = 0; i < HB; i++) begin
			hdr_nxt[i] = (cnt_q == CW'(i)) ? beat_s1.data_byte : hdr_q[i];
		end
	end

	// CRC field bytes count as zero
	assign crc_in  = (cnt_q >= CW'(sfc_pkg::CRC_POS) && cnt_q < CW'(HB)) ?
		8'd0 : beat_s1.data_byte;
	assign crc_nxt = sfc_pkg::crc_byte(crc_q, crc_in);
	assign len     = (cnt_q == sfc_pkg::CNT_MAX) ? cnt_q : cnt_q + CW'(1);

	assign f_version  = {hdr_nxt[5], hdr_nxt[4]};
	assign f_hdr_size = {hdr_nxt[7], hdr_nxt[6]};
	assign f_type     = {hdr_nxt[9], hdr_nxt[8]};
	assign f_flags    = {hdr_nxt[11], hdr_nxt[10]};
	assign f_frame    = {hdr_nxt[19], hdr_nxt[18], hdr_nxt[17], hdr_nxt[16],
		hdr_nxt[15], hdr_nxt[14], hdr_nxt[13], hdr_nxt[12]};
	assign f_rng      = {hdr_nxt[27], hdr_nxt[26], hdr_nxt[25], hdr_nxt[24],
		hdr_nxt[23], hdr_nxt[22], hdr_nxt[21], hdr_nxt[20]};
	assign f_size     = {hdr_nxt[31], hdr_nxt[30], hdr_nxt[29], hdr_nxt[28]};
	assign f_crc      = {hdr_nxt[35], hdr_nxt[34], hdr_nxt[33], hdr_nxt[32]};
	assign magic_ok   = hdr_nxt[0] == sfc_pkg::MAGIC_0 && hdr_nxt[1] == sfc_pkg::MAGIC_1 &&
		hdr_nxt[2] == sfc_pkg::MAGIC_2 && hdr_nxt[3] == sfc_pkg::MAGIC_3;

	// first failing check in header order wins
	always_comb begin
		if (len < CW'(HB))
			status = sfc_pkg::ST_TRUNC;
		else if (!magic_ok)
			status = sfc_pkg::ST_MAGIC;
		else if (f_version != cfg.expected_version)
			status = sfc_pkg::ST_VERSION;
		else if (f_hdr_size != 16'(HB))
			status = sfc_pkg::ST_HDR_SIZE;
		else if (f_type == 16'd0)
			status = sfc_pkg::ST_TYPE_ZERO;
		else if (f_size > 32'(cfg.max_payload))
			status = sfc_pkg::ST_TOO_LARGE;
		else if (len == sfc_pkg::CNT_MAX || 33'(f_size) != 33'(len) - 33'(HB))
			status = sfc_pkg::ST_SIZE_MISM;
		else if ((crc_nxt ^ sfc_pkg::CRC_INIT) != f_crc)
			status = sfc_pkg::ST_CRC;
		else
			status = sfc_pkg::ST_OK;
	end

	// frame state; a last byte re-arms everything for the next frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= sfc_pkg::CRC_INIT;
			for (int i = 0; i < HB; i++) hdr_q[i] <= 8'd0;
		end else if (fire) begin
			if (beat_s1.last_byte) begin
				cnt_q <= '0;
				crc_q <= sfc_pkg::CRC_INIT;
				for (int i = 0; i < HB; i++) hdr_q[i] <= 8'd0;
			end else begin
				cnt_q <= len;
				crc_q <= crc_nxt;
				for (int i = 0; i < HB; i++) hdr_q[i] <= hdr_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (res_valid_q && !result.ready) || (fire && beat_s1.last_byte);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && beat_s1.last_byte) begin
			res_status_q  <= status;
			res_version_q <= f_version;
			res_type_q    <= f_type;
			res_flags_q   <= f_flags;
			res_frame_q   <= f_frame;
			res_rng_q     <= f_rng;
			res_size_q    <= f_size;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.status           = res_status_q;
	assign result.hdr_version      = res_version_q;
	assign result.hdr_payload_type = res_type_q;
	assign result.hdr_flags        = res_flags_q;
	assign result.hdr_frame_number = res_frame_q;
	assign result.hdr_rng_state    = res_rng_q;
	assign result.hdr_payload_size = res_size_q;

	`SFC_ASSERT_NEXT(a_last_gives_result, fire && beat_s1.last_byte, res_valid_q,
		"last byte did not load the result register")
	`SFC_ASSERT_NEXT(a_last_rearms, fire && beat_s1.last_byte,
		cnt_q == '0 && crc_q == sfc_pkg::CRC_INIT, "frame state not re-armed after last byte")
	`SFC_ASSERT_NEXT(a_stall_holds_state, stall, $stable(cnt_q) && $stable(crc_q),
		"frame state moved while the result register was blocked")
	`SFC_ASSERT_NOW(a_no_overwrite, res_valid_q && !result.ready, !(fire && beat_s1.last_byte),
		"pending result would be overwritten")

endmodule

### dv/tb_snapshot_frame_checker_core.sv
// Self-checking testbench for snapshot_frame_checker_core: builds snapshot frames, predicts each
// verdict from the accepted bytes and checks every result field.
// Depends on sfc_pkg, sfc_frame_if, sfc_result_if and the core RTL.
module tb_snapshot_frame_checker_core;

	// Kinds of frame the generator can build. Each one past the good frame, noise
	// apart, is aimed at one check of the header chain, in the order the block tests them.
	typedef enum int {
		FK_GOOD      = 0,
		FK_TRUNC     = 1,
		FK_MAGIC     = 2,
		FK_VERSION   = 3,
		FK_HDR_SIZE  = 4,
		FK_TYPE_ZERO = 5,
		FK_TOO_BIG   = 6,
		FK_SIZE_MISM = 7,
		FK_CRC       = 8,
		FK_NOISE     = 9
	} frame_kind_t;

	// Header field fill patterns
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ONES   = 1;
	localparam int FILL_ZEROS  = 2;

	localparam logic [7:0] MAGIC_SEQ [4] = '{sfc_pkg::MAGIC_0, sfc_pkg::MAGIC_1,
		sfc_pkg::MAGIC_2, sfc_pkg::MAGIC_3};

	typedef struct packed {
		sfc_pkg::status_t status;
		logic [15:0]      version;
		logic [15:0]      body_kind;
		logic [15:0]      flags;
		logic [63:0]      frame_number;
		logic [63:0]      gen_seed;
		logic [31:0]      body_len;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sfc_frame_if  frame_ch ();
	sfc_result_if result_ch ();

	snapshot_frame_checker_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// --- shared bookkeeping -------------------------------------------------
	sfc_pkg::beat_t pending_beats [$];    // bytes queued for the driver, not yet presented
	verdict_t       pending_verdicts [$]; // predicted results, oldest first
	int             beats_pushed   = 0;
	int             beats_accepted = 0;
	int             mismatches     = 0;
	bit             stall_en       = 1'b1; // random idling on both channels
	int             send_gap       = 0;
	int             recv_gap       = 0;
	sfc_pkg::beat_t next_beat;
	verdict_t       want;

	// Copy of the register file, updated right after each APB write.
	logic [15:0] cfg_version;
	logic [26:0] cfg_max_payload;

	// Frame state of the prediction
	logic [26:0] fr_count;
	logic [31:0] fr_crc;
	logic        fr_magic_ok;
	logic [15:0] fr_version;
	logic [15:0] fr_hdr_size;
	logic [15:0] fr_ptype;
	logic [15:0] fr_flags;
	logic [63:0] fr_fnum;
	logic [63:0] fr_rng;
	logic [31:0] fr_psize;
	logic [31:0] fr_crc_field;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_v);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, exp_v);
		mismatches++;
	endtask

	// Reflected CRC-32, one data bit at a time, LSB first.
	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb)
				c = c ^ sfc_pkg::CRC_POLY;
		end
		return c;
	endfunction

	task automatic clear_frame_state();
		fr_count     = '0;
		fr_crc       = sfc_pkg::CRC_INIT;
		fr_magic_ok  = 1'b1;
		fr_version   = '0;
		fr_hdr_size  = '0;
		fr_ptype     = '0;
		fr_flags     = '0;
		fr_fnum      = '0;
		fr_rng       = '0;
		fr_psize     = '0;
		fr_crc_field = '0;
	endtask

	// Folds one accepted byte into the frame state; on a last byte it queues
	// the verdict and re-arms for the next frame.
	task automatic frame_check_byte(input logic [7:0] b, input logic lst);
		int          pos;
		logic [26:0] len;
		verdict_t    v;
		pos = int'(fr_count);
		if (pos < 4) begin
			if (b != MAGIC_SEQ[pos])
				fr_magic_ok = 1'b0;
		end else if (pos < 6) begin
			fr_version[8*(pos-4) +: 8] = b;
		end else if (pos < 8) begin
			fr_hdr_size[8*(pos-6) +: 8] = b;
		end else if (pos < 10) begin
			fr_ptype[8*(pos-8) +: 8] = b;
		end else if (pos < 12) begin
			fr_flags[8*(pos-10) +: 8] = b;
		end else if (pos < 20) begin
			fr_fnum[8*(pos-12) +: 8] = b;
		end else if (pos < 28) begin
			fr_rng[8*(pos-20) +: 8] = b;
		end else if (pos < sfc_pkg::CRC_POS) begin
			fr_psize[8*(pos-28) +: 8] = b;
		end else if (pos < sfc_pkg::HEADER_BYTES) begin
			fr_crc_field[8*(pos-sfc_pkg::CRC_POS) +: 8] = b;
		end
		// the CRC field itself enters the checksum as zeros
		if (pos >= sfc_pkg::CRC_POS && pos < sfc_pkg::HEADER_BYTES)
			fr_crc = crc32_step(fr_crc, 8'h00);
		else
			fr_crc = crc32_step(fr_crc, b);
		if (fr_count != sfc_pkg::CNT_MAX)
			fr_count = fr_count + 27'd1;
		if (lst) begin
			len = fr_count;
			// first failing check wins
			if (len < sfc_pkg::HEADER_BYTES)
				v.status = sfc_pkg::ST_TRUNC;
			else if (!fr_magic_ok)
				v.status = sfc_pkg::ST_MAGIC;
			else if (fr_version != cfg_version)
				v.status = sfc_pkg::ST_VERSION;
			else if (fr_hdr_size != 16'(sfc_pkg::HEADER_BYTES))
				v.status = sfc_pkg::ST_HDR_SIZE;
			else if (fr_ptype == '0)
				v.status = sfc_pkg::ST_TYPE_ZERO;
			else if (fr_psize > {5'b0, cfg_max_payload})
				v.status = sfc_pkg::ST_TOO_LARGE;
			else if (len == sfc_pkg::CNT_MAX ||
					64'(fr_psize) != 64'(len) - 64'(sfc_pkg::HEADER_BYTES))
				v.status = sfc_pkg::ST_SIZE_MISM;
			else if (~fr_crc != fr_crc_field)
				v.status = sfc_pkg::ST_CRC;
			else
				v.status = sfc_pkg::ST_OK;
			v.version      = fr_version;
			v.body_kind    = fr_ptype;
			v.flags        = fr_flags;
			v.frame_number = fr_fnum;
			v.gen_seed     = fr_rng;
			v.body_len     = fr_psize;
			pending_verdicts.push_back(v);
			clear_frame_state();
		end
	endtask

	// --- byte driver --------------------------------------------------------
	// Predicts on the transfer edge, then presents the next queued byte unless
	// an idle burst is running. valid gets at most one assignment per edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			frame_ch.valid     <= 1'b0;
			frame_ch.data_byte <= '0;
			frame_ch.last_byte <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				frame_check_byte(frame_ch.data_byte, frame_ch.last_byte);
				beats_accepted++;
			end
			if (!frame_ch.valid || frame_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					frame_ch.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					next_beat = pending_beats.pop_front();
					frame_ch.valid     <= 1'b1;
					frame_ch.data_byte <= next_beat.data_byte;
					frame_ch.last_byte <= next_beat.last_byte;
					// idle burst after this transfer
					if (stall_en && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 9);
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// --- result monitor -----------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					flag_mismatch("result with no frame pending", 64'(result_ch.status), 64'd0);
				end else begin
					want = pending_verdicts.pop_front();
					if (result_ch.status != want.status)
						flag_mismatch("status", 64'(result_ch.status), 64'(want.status));
					if (result_ch.hdr_version != want.version)
						flag_mismatch("hdr_version", 64'(result_ch.hdr_version),
							64'(want.version));
					if (result_ch.hdr_payload_type != want.body_kind)
						flag_mismatch("hdr_payload_type", 64'(result_ch.hdr_payload_type),
							64'(want.body_kind));
					if (result_ch.hdr_flags != want.flags)
						flag_mismatch("hdr_flags", 64'(result_ch.hdr_flags), 64'(want.flags));
					if (result_ch.hdr_frame_number != want.frame_number)
						flag_mismatch("hdr_frame_number", result_ch.hdr_frame_number,
							want.frame_number);
					if (result_ch.hdr_rng_state != want.gen_seed)
						flag_mismatch("hdr_rng_state", result_ch.hdr_rng_state, want.gen_seed);
					if (result_ch.hdr_payload_size != want.body_len)
						flag_mismatch("hdr_payload_size", 64'(result_ch.hdr_payload_size),
							64'(want.body_len));
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (stall_en && $urandom_range(0, 4) == 0)
					recv_gap = $urandom_range(1, 9);
			end
		end
	end

	// --- stimulus helpers ---------------------------------------------------
	task automatic push_beat(input logic [7:0] b, input logic lst);
		sfc_pkg::beat_t nb;
		nb.data_byte = b;
		nb.last_byte = lst;
		pending_beats.push_back(nb);
		beats_pushed++;
	endtask

	// Blocks until every queued byte went through and every verdict came back.
	task automatic wait_drained();
		while (beats_accepted != beats_pushed || pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Reads a register back and compares it with the local copy.
	task automatic apb_check(input sfc_pkg::reg_idx_t idx);
		logic [31:0] exp_v;
		exp_v = (idx == sfc_pkg::REG_EXP_VERSION) ? {16'b0, cfg_version} :
			{5'b0, cfg_max_payload};
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata != exp_v)
			flag_mismatch("register readback", 64'(prdata), 64'(exp_v));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Setup then access; the register takes the value on the access edge.
	task automatic apb_write(input sfc_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == sfc_pkg::REG_EXP_VERSION)
			cfg_version = val[15:0];
		else
			cfg_max_payload = val[26:0];
		apb_check(idx);
	endtask

	// Builds one frame and queues its bytes. plen < 0 picks a payload length,
	// mostly short; cut > 0 sets the length of a truncated frame.
	task automatic send_frame(input frame_kind_t kind, input int plen, input int fill,
			input int cut);
		logic [7:0]  hdr [sfc_pkg::HEADER_BYTES];
		logic [7:0]  body [$];
		logic [15:0] ver;
		logic [15:0] hsize;
		logic [15:0] ptype;
		logic [15:0] flags;
		logic [63:0] fnum;
		logic [63:0] rng;
		logic [31:0] psize;
		logic [31:0] crc;
		int          n;
		int          room;
		if (kind == FK_NOISE) begin
			// unframed bytes, stray last marks included
			n = $urandom_range(1, 60);
			for (int i = 0; i < n; i++)
				push_beat(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0));
			return;
		end
		if (plen < 0) begin
			n = $urandom_range(0, 9);
			if (n < 7)
				plen = $urandom_range(0, 16);
			else if (n < 9)
				plen = $urandom_range(17, 64);
			else
				plen = $urandom_range(65, 200);
			if (kind != FK_TOO_BIG && plen > int'(cfg_max_payload))
				plen = int'(cfg_max_payload);
		end
		ver   = cfg_version;
		hsize = 16'(sfc_pkg::HEADER_BYTES);
		case (fill)
			FILL_ONES: begin
				ptype = '1;
				flags = '1;
				fnum  = '1;
				rng   = '1;
			end
			FILL_ZEROS: begin
				ptype = 16'd1;
				flags = '0;
				fnum  = '0;
				rng   = '0;
			end
			default: begin
				ptype = 16'($urandom);
				if (ptype == '0)
					ptype = 16'd1;
				flags = 16'($urandom);
				fnum  = {$urandom, $urandom};
				rng   = {$urandom, $urandom};
			end
		endcase
		psize = 32'(plen);
		case (kind)
			FK_VERSION:   ver   = ver ^ 16'($urandom_range(1, 65535));
			FK_HDR_SIZE:  hsize = hsize ^ 16'($urandom_range(1, 65535));
			FK_TYPE_ZERO: ptype = '0;
			FK_TOO_BIG: begin
				if (fill == FILL_ONES)
					psize = '1;
				else
					psize = 32'(cfg_max_payload) + 32'd1 + ($urandom_range(0, 1) ?
						32'($urandom_range(0, 1000)) : ($urandom >> 6));
			end
			FK_SIZE_MISM: begin
				// stay within max_payload so the size check is the one that trips
				room = int'(cfg_max_payload) - plen;
				if (room > 0 && (plen == 0 || $urandom_range(0, 1)))
					psize = 32'(plen + $urandom_range(1, (room > 8) ? 8 : room));
				else if (plen > 0)
					psize = 32'($urandom_range(0, plen - 1));
				else begin
					plen  = 1;
					psize = '0;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++) begin
			hdr[i]      = MAGIC_SEQ[i];
			hdr[28 + i] = psize[8*i +: 8];
		end
		for (int i = 0; i < 2; i++) begin
			hdr[4 + i]  = ver[8*i +: 8];
			hdr[6 + i]  = hsize[8*i +: 8];
			hdr[8 + i]  = ptype[8*i +: 8];
			hdr[10 + i] = flags[8*i +: 8];
		end
		for (int i = 0; i < 8; i++) begin
			hdr[12 + i] = fnum[8*i +: 8];
			hdr[20 + i] = rng[8*i +: 8];
		end
		if (kind == FK_MAGIC) begin
			n = $urandom_range(0, 3);
			hdr[n] = hdr[n] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < plen; i++)
			body.push_back(8'($urandom));
		crc = sfc_pkg::CRC_INIT;
		for (int i = 0; i < sfc_pkg::CRC_POS; i++)
			crc = crc32_step(crc, hdr[i]);
		for (int i = sfc_pkg::CRC_POS; i < sfc_pkg::HEADER_BYTES; i++)
			crc = crc32_step(crc, 8'h00);
		foreach (body[i])
			crc = crc32_step(crc, body[i]);
		crc = ~crc;
		if (kind == FK_CRC) begin
			// either a damaged payload byte or a damaged CRC field
			if (plen > 0 && $urandom_range(0, 1)) begin
				n = $urandom_range(0, plen - 1);
				body[n] = body[n] ^ 8'($urandom_range(1, 255));
			end else begin
				crc = crc ^ (32'd1 << $urandom_range(0, 31));
			end
		end
		for (int i = 0; i < 4; i++)
			hdr[sfc_pkg::CRC_POS + i] = crc[8*i +: 8];
		n = sfc_pkg::HEADER_BYTES + plen;
		if (kind == FK_TRUNC)
			n = (cut > 0) ? cut : $urandom_range(1, sfc_pkg::HEADER_BYTES - 1);
		for (int i = 0; i < n; i++)
			push_beat((i < sfc_pkg::HEADER_BYTES) ? hdr[i] : body[i - sfc_pkg::HEADER_BYTES],
				i == n - 1);
	endtask

	// --- main sequence ------------------------------------------------------
	initial begin
		int          r;
		int          phase_start;
		int          fill;
		frame_kind_t kind;

		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		clear_frame_state();
		cfg_version     = sfc_pkg::EXP_VERSION_RST;
		cfg_max_payload = sfc_pkg::MAX_PAYLOAD_RST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults after reset
		apb_check(sfc_pkg::REG_EXP_VERSION);
		apb_check(sfc_pkg::REG_MAX_PAYLOAD);

		// Directed frames under the reset settings: one per check, the
		// single-byte frame, a header cut one byte short, field extremes.
		send_frame(FK_GOOD, 0, FILL_ZEROS, 0);
		send_frame(FK_GOOD, 5, FILL_ONES, 0);
		send_frame(FK_TRUNC, 0, FILL_RANDOM, 1);
		send_frame(FK_TRUNC, 0, FILL_ONES, sfc_pkg::HEADER_BYTES - 1);
		send_frame(FK_MAGIC, 3, FILL_RANDOM, 0);
		send_frame(FK_VERSION, 2, FILL_RANDOM, 0);
		send_frame(FK_HDR_SIZE, 1, FILL_RANDOM, 0);
		send_frame(FK_TYPE_ZERO, 0, FILL_RANDOM, 0);
		send_frame(FK_TOO_BIG, 2, FILL_ONES, 0);
		send_frame(FK_SIZE_MISM, 4, FILL_RANDOM, 0);
		send_frame(FK_CRC, 6, FILL_RANDOM, 0);
		send_frame(FK_NOISE, 0, FILL_RANDOM, 0);
		send_frame(FK_GOOD, -1, FILL_RANDOM, 0);

		// Random phases, each under its own register setting. The last phase
		// runs with no idling on either side.
		for (int ph = 0; ph < 5; ph++) begin
			// block must be idle before touching the registers; the extra
			// cycles add margin after the last result transfer
			wait_drained();
			repeat (4) @(posedge clk);
			case (ph)
				0: begin
					apb_write(sfc_pkg::REG_EXP_VERSION, 32'hFFFF);
					apb_write(sfc_pkg::REG_MAX_PAYLOAD, 32'd0);
				end
				1: begin
					apb_write(sfc_pkg::REG_EXP_VERSION, 32'd0);
					apb_write(sfc_pkg::REG_MAX_PAYLOAD, 32'(sfc_pkg::MAX_PAYLOAD_RST));
				end
				2: begin
					apb_write(sfc_pkg::REG_EXP_VERSION, 32'($urandom_range(0, 65535)));
					apb_write(sfc_pkg::REG_MAX_PAYLOAD, 32'($urandom_range(0, 300)));
				end
				3: begin
					apb_write(sfc_pkg::REG_EXP_VERSION, 32'($urandom_range(0, 65535)));
					apb_write(sfc_pkg::REG_MAX_PAYLOAD, 32'($urandom_range(0, 40)));
				end
				default: begin
					apb_write(sfc_pkg::REG_EXP_VERSION, 32'(sfc_pkg::EXP_VERSION_RST));
					apb_write(sfc_pkg::REG_MAX_PAYLOAD, 32'(sfc_pkg::MAX_PAYLOAD_RST));
				end
			endcase
			phase_start = beats_pushed;
			while (beats_pushed - phase_start < 40) begin
				// keep the queue short so idling choices track the frames
				while (pending_beats.size() > 8)
					@(posedge clk);
				stall_en = (ph != 4) && ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 19);
				if (r < 8)
					kind = FK_GOOD;
				else if (r >= 18)
					kind = FK_NOISE;
				else if (r >= 16)
					kind = FK_CRC;
				else if (r >= 14)
					kind = FK_SIZE_MISM;
				else
					kind = frame_kind_t'(r - 7);
				r    = $urandom_range(0, 19);
				fill = (r == 0) ? FILL_ONES : (r == 1) ? FILL_ZEROS : FILL_RANDOM;
				send_frame(kind, -1, fill, 0);
				// now and then the sender holds off until every result is in
				if ($urandom_range(0, 9) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_snapshot_frame_checker_core passed");
		else
			$display("tb_snapshot_frame_checker_core failed");
		$finish;
	end

	// Watchdog, well past the slowest legal run
	initial begin
		#5000000;
		$display("tb_snapshot_frame_checker_core failed");
		$finish;
	end

endmodule
